/* hw/rtl/pawu_pkg.sv */
`timescale 1ns / 1ps

// Shared types and constants of the PID step unit with anti-windup feedback.
package pawu_pkg;

  // Gains are unsigned Q8.8; every gain product is shifted right by this many bits.
  localparam int unsigned GAIN_FRAC_BITS = 8;
  // Symmetric clamp magnitude of the derivative term.
  localparam int unsigned D_LIMIT = 1073741824;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_P_GAIN      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_I_GAIN      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_D_GAIN      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDUP_GAIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_P_LIMIT     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_I_LIMIT     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN     = 3'd7;

  // Register values after reset.
  localparam logic [15:0]        P_GAIN_RST  = 16'd256;
  localparam logic [15:0]        GAIN_RST    = 16'd0;
  localparam logic [30:0]        LIMIT_RST   = 31'h7FFF_FFFF;
  localparam logic signed [31:0] OUT_MAX_RST = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] OUT_MIN_RST = 32'sh8000_0000;

  // Request operation codes.
  localparam logic OP_COMPUTE = 1'b0;
  localparam logic OP_CLEAR   = 1'b1;

  // Sequencer steps; the controller state and the datapath step command share them.
  localparam int unsigned STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_IDLE    = 4'd0;
  localparam logic [STEP_W-1:0] STEP_MUL_P   = 4'd1;
  localparam logic [STEP_W-1:0] STEP_CLAMP_P = 4'd2;
  localparam logic [STEP_W-1:0] STEP_MUL_I   = 4'd3;
  localparam logic [STEP_W-1:0] STEP_ACC_I   = 4'd4;
  localparam logic [STEP_W-1:0] STEP_COMB_W  = 4'd5;
  localparam logic [STEP_W-1:0] STEP_ACC_W   = 4'd6;
  localparam logic [STEP_W-1:0] STEP_CLAMP_I = 4'd7;
  localparam logic [STEP_W-1:0] STEP_SUM     = 4'd8;
  localparam logic [STEP_W-1:0] STEP_DONE    = 4'd9;

  typedef struct packed {
    logic              op;
    logic signed [15:0] reference;
    logic signed [15:0] feedback;
  } req_t;

  typedef struct packed {
    logic signed [31:0] drive;
    logic              saturated;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              load_in;
    logic              clear_int;
    logic              finish;
    logic [STEP_W-1:0] step;
  } cmd_t;

endpackage

/* hw/rtl/pawu_ctrl.sv */
`timescale 1ns / 1ps

// Sequencer: walks one compute request through the datapath steps and owns
// the handshakes on both channels.
module pawu_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_op_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output pawu_pkg::cmd_t  cmd_o
);

  logic [pawu_pkg::STEP_W-1:0] state_q, state_d;
  logic                        out_valid_q, out_valid_d;
  logic                        in_acc;

  assign in_ready_o  = (state_q == pawu_pkg::STEP_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d         = state_q;
    cmd_o.load_in   = 1'b0;
    cmd_o.clear_int = 1'b0;
    cmd_o.finish    = 1'b0;
    cmd_o.step      = state_q;
    unique case (state_q)
      pawu_pkg::STEP_IDLE: begin
        if (in_acc) begin
          if (in_op_i == pawu_pkg::OP_CLEAR) begin
            cmd_o.clear_int = 1'b1;
          end else begin
            cmd_o.load_in = 1'b1;
            state_d       = pawu_pkg::STEP_MUL_P;
          end
        end
      end
      pawu_pkg::STEP_MUL_P:   state_d = pawu_pkg::STEP_CLAMP_P;
      pawu_pkg::STEP_CLAMP_P: state_d = pawu_pkg::STEP_MUL_I;
      pawu_pkg::STEP_MUL_I:   state_d = pawu_pkg::STEP_ACC_I;
      pawu_pkg::STEP_ACC_I:   state_d = pawu_pkg::STEP_COMB_W;
      pawu_pkg::STEP_COMB_W:  state_d = pawu_pkg::STEP_ACC_W;
      pawu_pkg::STEP_ACC_W:   state_d = pawu_pkg::STEP_CLAMP_I;
      pawu_pkg::STEP_CLAMP_I: state_d = pawu_pkg::STEP_SUM;
      pawu_pkg::STEP_SUM:     state_d = pawu_pkg::STEP_DONE;
      pawu_pkg::STEP_DONE: begin
        // The state update and the output load happen together, once the
        // output register is free or being emptied.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          state_d      = pawu_pkg::STEP_IDLE;
        end
      end
      default: state_d = pawu_pkg::STEP_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pawu_pkg::STEP_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_result_from_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == pawu_pkg::STEP_DONE)
    else $error("result appeared without a finished step");

  a_done_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pawu_pkg::STEP_DONE && out_valid_q && !out_ready_i)
    |=> state_q == pawu_pkg::STEP_DONE)
    else $error("finished step overwrote a pending result");

  a_clear_stays_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_op_i == pawu_pkg::OP_CLEAR) |=> state_q == pawu_pkg::STEP_IDLE)
    else $error("clear request started a computation");

  a_compute_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_op_i == pawu_pkg::OP_COMPUTE) |=> state_q == pawu_pkg::STEP_MUL_P)
    else $error("compute request did not start the sequence");

endmodule

/* hw/rtl/pawu_datapath.sv */
`timescale 1ns / 1ps

// Datapath: configuration registers, controller state, one shared
// 17 x 26 bit signed multiplier and the clamps.
module pawu_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [pawu_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [pawu_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  pawu_pkg::req_t                      in_req_i,
  input  pawu_pkg::cmd_t                      cmd_i,
  output pawu_pkg::rsp_t                      out_rsp_o
);

  logic [15:0]        p_gain_q, i_gain_q, d_gain_q, windup_gain_q;
  logic [30:0]        p_limit_q, i_limit_q;
  logic signed [31:0] out_max_q, out_min_q;

  logic signed [31:0] integral_q;
  logic signed [25:0] prev_q;
  logic signed [33:0] we_q;

  logic signed [16:0] err_q;
  logic signed [42:0] prod_q;
  logic signed [25:0] p_q, diff_q;
  logic [32:0]        wlo_q;
  logic signed [49:0] wfull_q;
  logic signed [43:0] acc_q;
  logic signed [31:0] d_q;
  logic signed [33:0] sum_q;
  logic signed [31:0] drive_q;
  logic               sat_q;

  logic [15:0]        mul_gain;
  logic signed [25:0] mul_b;
  logic signed [42:0] mul_p;

  logic signed [34:0] p_shift, p_lim, p_clamped;
  logic signed [34:0] d_shift, d_lim, d_clamped;
  logic signed [43:0] i_lim, i_clamped;
  logic signed [31:0] drive_n;
  logic signed [34:0] we_wide;

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_gain = p_gain_q;
    mul_b    = 26'(err_q);
    unique case (cmd_i.step)
      pawu_pkg::STEP_MUL_P: begin
        mul_gain = p_gain_q;
        mul_b    = 26'(err_q);
      end
      pawu_pkg::STEP_CLAMP_P: begin
        mul_gain = windup_gain_q;
        mul_b    = $signed({10'b0, we_q[15:0]});
      end
      pawu_pkg::STEP_MUL_I: begin
        mul_gain = i_gain_q;
        mul_b    = p_q;
      end
      pawu_pkg::STEP_ACC_I: begin
        mul_gain = windup_gain_q;
        mul_b    = $signed({{8{we_q[33]}}, we_q[33:16]});
      end
      pawu_pkg::STEP_COMB_W: begin
        mul_gain = d_gain_q;
        mul_b    = diff_q;
      end
      default: begin
        mul_gain = p_gain_q;
        mul_b    = 26'(err_q);
      end
    endcase
  end

  assign mul_p = $signed({1'b0, mul_gain}) * mul_b;

  // Proportional clamp.
  always_comb begin
    p_shift = 35'(prod_q >>> pawu_pkg::GAIN_FRAC_BITS);
    p_lim   = $signed({4'b0, p_limit_q});
    if (p_shift > p_lim) begin
      p_clamped = p_lim;
    end else if (p_shift < -p_lim) begin
      p_clamped = -p_lim;
    end else begin
      p_clamped = p_shift;
    end
  end

  // Derivative clamp.
  always_comb begin
    d_shift = 35'(prod_q >>> pawu_pkg::GAIN_FRAC_BITS);
    d_lim   = $signed(35'(pawu_pkg::D_LIMIT));
    if (d_shift > d_lim) begin
      d_clamped = d_lim;
    end else if (d_shift < -d_lim) begin
      d_clamped = -d_lim;
    end else begin
      d_clamped = d_shift;
    end
  end

  // Integral clamp.
  always_comb begin
    i_lim = $signed({13'b0, i_limit_q});
    if (acc_q > i_lim) begin
      i_clamped = i_lim;
    end else if (acc_q < -i_lim) begin
      i_clamped = -i_lim;
    end else begin
      i_clamped = acc_q;
    end
  end

  // Output clamp; the upper bound is checked first when the bounds cross.
  always_comb begin
    if (sum_q > 34'(out_max_q)) begin
      drive_n = out_max_q;
    end else if (sum_q < 34'(out_min_q)) begin
      drive_n = out_min_q;
    end else begin
      drive_n = sum_q[31:0];
    end
    we_wide = 35'(drive_n) - 35'(sum_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_gain_q      <= pawu_pkg::P_GAIN_RST;
      i_gain_q      <= pawu_pkg::GAIN_RST;
      d_gain_q      <= pawu_pkg::GAIN_RST;
      windup_gain_q <= pawu_pkg::GAIN_RST;
      p_limit_q     <= pawu_pkg::LIMIT_RST;
      i_limit_q     <= pawu_pkg::LIMIT_RST;
      out_max_q     <= pawu_pkg::OUT_MAX_RST;
      out_min_q     <= pawu_pkg::OUT_MIN_RST;
      integral_q    <= '0;
      prev_q        <= '0;
      we_q          <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          pawu_pkg::REG_P_GAIN:      p_gain_q      <= cfg_data_i[15:0];
          pawu_pkg::REG_I_GAIN:      i_gain_q      <= cfg_data_i[15:0];
          pawu_pkg::REG_D_GAIN:      d_gain_q      <= cfg_data_i[15:0];
          pawu_pkg::REG_WINDUP_GAIN: windup_gain_q <= cfg_data_i[15:0];
          pawu_pkg::REG_P_LIMIT:     p_limit_q     <= cfg_data_i[30:0];
          pawu_pkg::REG_I_LIMIT:     i_limit_q     <= cfg_data_i[30:0];
          pawu_pkg::REG_OUT_MAX:     out_max_q     <= cfg_data_i;
          pawu_pkg::REG_OUT_MIN:     out_min_q     <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.clear_int) begin
        integral_q <= '0;
      end else if (cmd_i.step == pawu_pkg::STEP_CLAMP_I) begin
        integral_q <= i_clamped[31:0];
      end
      if (cmd_i.finish) begin
        we_q   <= we_wide[33:0];
        prev_q <= p_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_p;
    if (cmd_i.load_in) begin
      err_q <= 17'(in_req_i.reference) - 17'(in_req_i.feedback);
    end
    if (cmd_i.step == pawu_pkg::STEP_CLAMP_P) begin
      p_q <= p_clamped[25:0];
    end
    if (cmd_i.step == pawu_pkg::STEP_MUL_I) begin
      wlo_q  <= prod_q[32:0];
      diff_q <= p_q - prev_q;
    end
    if (cmd_i.step == pawu_pkg::STEP_ACC_I) begin
      acc_q <= 44'(integral_q) + 44'(prod_q >>> pawu_pkg::GAIN_FRAC_BITS);
    end
    if (cmd_i.step == pawu_pkg::STEP_COMB_W) begin
      // High partial product of the anti-windup term rejoins the low one.
      wfull_q <= $signed({prod_q[33:0], 16'b0}) + $signed({17'b0, wlo_q});
    end
    if (cmd_i.step == pawu_pkg::STEP_ACC_W) begin
      acc_q <= acc_q + 44'(wfull_q >>> pawu_pkg::GAIN_FRAC_BITS);
      d_q   <= d_clamped[31:0];
    end
    if (cmd_i.step == pawu_pkg::STEP_SUM) begin
      sum_q <= 34'(p_q) + 34'(integral_q) + 34'(d_q);
    end
    if (cmd_i.finish) begin
      drive_q <= drive_n;
      sat_q   <= (34'(drive_n) != sum_q);
    end
  end

  assign out_rsp_o.drive     = drive_q;
  assign out_rsp_o.saturated = sat_q;

endmodule

/* hw/rtl/pid_anti_windup_step_unit.sv */
`timescale 1ns / 1ps

// Channel   Direction  Handshake                  Payload
// in        request    in_valid_i / in_ready_o    in_req_i  (op, reference, feedback)
// out       result     out_valid_o / out_ready_i  out_rsp_o (drive, saturated)
// cfg       write      cfg_we_i                   cfg_index_i, cfg_data_i
//
// A compute request walks the sequencer through its steps from acceptance until its result is
// loaded into the output register. The sequencer then returns to idle before it can take the
// next request, so a new compute request is taken only once the last one is through; a clear
// request gives no result. The steps come from the sequencer driving one shared 17 x 26 bit
// multiplier through five products (the anti-windup product is formed from two halves), with
// a register after every product and clamp.
// Reset clears the sequencer, the output valid flag, the controller state and loads the
// configuration registers with their documented reset values.
// A stalled output holds the sequencer in its final step; a new request is still taken
// while an earlier result waits in the output register.
module pid_anti_windup_step_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  pawu_pkg::req_t                  in_req_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output pawu_pkg::rsp_t                  out_rsp_o,
  input  logic                            cfg_we_i,
  input  logic [pawu_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pawu_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  // Commands from the sequencer to the datapath.
  pawu_pkg::cmd_t cmd;

  // The sequencer sees only the operation bit of the request; the datapath
  // captures the samples when the sequencer tells it to.
  pawu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_op_i     (in_req_i.op),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // The datapath holds the gains, limits, integral, previous proportional
  // term and anti-windup error, and the output register payload.
  pawu_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_req_i    (in_req_i),
    .cmd_i       (cmd),
    .out_rsp_o   (out_rsp_o)
  );

endmodule
